/* rtl/trs_affine_matrix_builder_top_defines.svh */
// Assertion helpers used by the file that checks the matrix builder top.
`ifndef TRS_AFFINE_MATRIX_BUILDER_TOP_DEFINES_SVH
`define TRS_AFFINE_MATRIX_BUILDER_TOP_DEFINES_SVH

// Checked only while the block is out of reset.
`define TRS_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define TRS_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/trs_pkg.sv */
`default_nettype none
package trs_pkg;

	// Angle resolution used for sine and cosine, 8 to 16 bits.
	localparam int ANGLE_BITS = 16;
	localparam logic [31:0] PHASE_KEEP = ~((32'(1) << (32 - ANGLE_BITS)) - 32'(1));

	localparam int CORDIC_STEPS = 17;
	localparam int STEP_W = 5;
	localparam int CW = 34;
	localparam logic signed [CW-1:0] CORDIC_GAIN = CW'(652032874);

	typedef struct packed {
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [31:0] pos_z;
		logic [15:0] angle_x;
		logic [15:0] angle_y;
		logic [15:0] angle_z;
		logic signed [15:0] scale_x;
		logic signed [15:0] scale_y;
		logic signed [15:0] scale_z;
	} in_item_t;

	typedef struct packed {
		logic signed [31:0] r0c0;
		logic signed [31:0] r0c1;
		logic signed [31:0] r0c2;
		logic signed [31:0] r0c3;
		logic signed [31:0] r1c0;
		logic signed [31:0] r1c1;
		logic signed [31:0] r1c2;
		logic signed [31:0] r1c3;
		logic signed [31:0] r2c0;
		logic signed [31:0] r2c1;
		logic signed [31:0] r2c2;
		logic signed [31:0] r2c3;
	} out_item_t;

	// One rotation in flight: vector, residual angle and quadrant.
	typedef struct packed {
		logic signed [CW-1:0] x;
		logic signed [CW-1:0] y;
		logic signed [CW-1:0] z;
		logic [1:0] quad;
	} cordic_lane_t;

	// Lanes for the x, y and z angles.
	typedef cordic_lane_t [2:0] cordic_vec_t;

	// Values that ride alongside the rotations.
	typedef struct packed {
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [31:0] pos_z;
		logic signed [15:0] scale_x;
		logic signed [15:0] scale_y;
		logic signed [15:0] scale_z;
	} side_t;

	// Arctangent of 2^-i in units of 2^-32 turn.
	function automatic logic signed [CW-1:0] atan_lut(input logic [STEP_W-1:0] i);
		logic signed [CW-1:0] r;
		case (i)
			5'd0: r = CW'(536870912);
			5'd1: r = CW'(316933406);
			5'd2: r = CW'(167458908);
			5'd3: r = CW'(85004756);
			5'd4: r = CW'(42667330);
			5'd5: r = CW'(21354465);
			5'd6: r = CW'(10679842);
			5'd7: r = CW'(5340245);
			5'd8: r = CW'(2670163);
			5'd9: r = CW'(1335087);
			5'd10: r = CW'(667544);
			5'd11: r = CW'(333772);
			5'd12: r = CW'(166886);
			5'd13: r = CW'(83443);
			5'd14: r = CW'(41721);
			5'd15: r = CW'(20861);
			5'd16: r = CW'(10430);
			default: r = '0;
		endcase
		return r;
	endfunction

	// Q1.30 times Q1.30, rounded half up back to Q1.30.
	function automatic logic signed [31:0] mul30(input logic signed [31:0] a,
			input logic signed [31:0] b);
		logic signed [63:0] p;
		p = (64'(a) * 64'(b)) + 64'sd536870912;
		return p[61:30];
	endfunction

	// Q1.30 sum times Q8.8 scale, rounded to Q16.16 and saturated.
	function automatic logic signed [31:0] scaled(input logic signed [32:0] r,
			input logic signed [15:0] k);
		logic signed [48:0] p;
		logic signed [48:0] v;
		logic signed [31:0] res;
		p = (49'(r) * 49'(k)) + 49'sd2097152;
		v = p >>> 22;
		if (v > 49'sd2147483647) begin
			res = 32'sh7FFFFFFF;
		end else if (v < -49'sd2147483648) begin
			res = 32'sh80000000;
		end else begin
			res = v[31:0];
		end
		return res;
	endfunction

endpackage
`default_nettype wire

/* rtl/trs_in_if.sv */
`default_nettype none
interface trs_in_if import trs_pkg::*; ();
	logic valid;
	logic ready;
	in_item_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface
`default_nettype wire

/* rtl/trs_out_if.sv */
`default_nettype none
interface trs_out_if import trs_pkg::*; ();
	logic valid;
	logic ready;
	out_item_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface
`default_nettype wire

/* rtl/trs_cordic_cell.sv */
`default_nettype none
// One CORDIC micro-rotation for all three angle lanes, registered.
module trs_cordic_cell import trs_pkg::*; (
	input wire logic clk,
	input wire logic en,
	input wire logic [STEP_W-1:0] step,
	input wire cordic_vec_t d_in,
	output cordic_vec_t d_out
);
	cordic_vec_t nxt;
	logic signed [CW-1:0] ang;

	always_comb begin
		ang = atan_lut(step);
		for (int l = 0; l < 3; l++) begin
			nxt[l].quad = d_in[l].quad;
			if (!d_in[l].z[CW-1]) begin
				nxt[l].x = d_in[l].x - (d_in[l].y >>> step);
				nxt[l].y = d_in[l].y + (d_in[l].x >>> step);
				nxt[l].z = d_in[l].z - ang;
			end else begin
				nxt[l].x = d_in[l].x + (d_in[l].y >>> step);
				nxt[l].y = d_in[l].y - (d_in[l].x >>> step);
				nxt[l].z = d_in[l].z + ang;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			d_out <= nxt;
		end
	end
endmodule
`default_nettype wire

/* rtl/trs_mtx_math.sv */
`default_nettype none
// Quadrant fold, angle products, entry sums and scaling over three stages.
module trs_mtx_math import trs_pkg::*; (
	input wire logic clk,
	input wire logic en,
	input wire cordic_vec_t rot,
	input wire side_t side,
	output out_item_t res
);
	logic signed [31:0] c [3];
	logic signed [31:0] s [3];

	always_comb begin
		for (int l = 0; l < 3; l++) begin
			case (rot[l].quad)
				2'd0: begin
					c[l] = rot[l].x[31:0];
					s[l] = rot[l].y[31:0];
				end
				2'd1: begin
					c[l] = -rot[l].y[31:0];
					s[l] = rot[l].x[31:0];
				end
				2'd2: begin
					c[l] = -rot[l].x[31:0];
					s[l] = -rot[l].y[31:0];
				end
				default: begin
					c[l] = rot[l].y[31:0];
					s[l] = -rot[l].x[31:0];
				end
			endcase
		end
	end

	// Lane 0 is the x angle, lane 1 y, lane 2 z.
	logic signed [31:0] cycz_s1, cysz_s1, sxsy_s1, cxsy_s1, cxsz_s1, cxcz_s1;
	logic signed [31:0] sxcy_s1, sxsz_s1, sxcz_s1, cxcy_s1, sy_s1, cz_s1, sz_s1;
	side_t side_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			cycz_s1 <= mul30(c[1], c[2]);
			cysz_s1 <= mul30(c[1], s[2]);
			sxsy_s1 <= mul30(s[0], s[1]);
			cxsy_s1 <= mul30(c[0], s[1]);
			cxsz_s1 <= mul30(c[0], s[2]);
			cxcz_s1 <= mul30(c[0], c[2]);
			sxcy_s1 <= mul30(s[0], c[1]);
			sxsz_s1 <= mul30(s[0], s[2]);
			sxcz_s1 <= mul30(s[0], c[2]);
			cxcy_s1 <= mul30(c[0], c[1]);
			sy_s1 <= s[1];
			cz_s1 <= c[2];
			sz_s1 <= s[2];
			side_s1 <= side;
		end
	end

	logic signed [32:0] e_s2 [9];
	side_t side_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			e_s2[0] <= 33'(cycz_s1);
			e_s2[1] <= -33'(cysz_s1);
			e_s2[2] <= 33'(sy_s1);
			e_s2[3] <= 33'(mul30(sxsy_s1, cz_s1)) + 33'(cxsz_s1);
			e_s2[4] <= 33'(cxcz_s1) - 33'(mul30(sxsy_s1, sz_s1));
			e_s2[5] <= -33'(sxcy_s1);
			e_s2[6] <= 33'(sxsz_s1) - 33'(mul30(cxsy_s1, cz_s1));
			e_s2[7] <= 33'(mul30(cxsy_s1, sz_s1)) + 33'(sxcz_s1);
			e_s2[8] <= 33'(cxcy_s1);
			side_s2 <= side_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res.r0c0 <= scaled(e_s2[0], side_s2.scale_x);
			res.r0c1 <= scaled(e_s2[1], side_s2.scale_y);
			res.r0c2 <= scaled(e_s2[2], side_s2.scale_z);
			res.r0c3 <= side_s2.pos_x;
			res.r1c0 <= scaled(e_s2[3], side_s2.scale_x);
			res.r1c1 <= scaled(e_s2[4], side_s2.scale_y);
			res.r1c2 <= scaled(e_s2[5], side_s2.scale_z);
			res.r1c3 <= side_s2.pos_y;
			res.r2c0 <= scaled(e_s2[6], side_s2.scale_x);
			res.r2c1 <= scaled(e_s2[7], side_s2.scale_y);
			res.r2c2 <= scaled(e_s2[8], side_s2.scale_z);
			res.r2c3 <= side_s2.pos_z;
		end
	end
endmodule
`default_nettype wire

/* rtl/trs_affine_matrix_builder_top.sv */
`default_nettype none
// Builds the top three rows of an entity's affine world matrix, translation times
// Rx*Ry*Rz times diagonal scale, in signed Q16.16 with saturation. The block takes
// one beat per clock cycle while the output side is not stalled and returns one
// beat per input beat, in order, through seventeen CORDIC cells, each one rotation
// step for the three angles, then one stage of angle products, one of entry sums
// and the scaling stage, which is also the output register. The whole pipeline
// advances together whenever the output register is empty or being taken, so
// input ready follows output ready within the same cycle.
`include "trs_affine_matrix_builder_top_defines.svh"
module trs_affine_matrix_builder_top import trs_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	trs_in_if.sink in_item,
	trs_out_if.source out_item
);
	logic adv;
	logic out_v_q;
	logic v_q [1:CORDIC_STEPS];
	logic va_q, vb_q;
	cordic_vec_t cd [0:CORDIC_STEPS];
	cordic_vec_t seed;
	side_t side_q [1:CORDIC_STEPS];
	side_t side_in;
	logic [15:0] ang [3];

	assign adv = !out_v_q || out_item.ready;
	assign in_item.ready = adv;

	// Seed the lanes: the binary angle becomes a phase whose top two bits pick
	// the quadrant and whose remainder is rotated out by the cells.
	always_comb begin
		logic [31:0] ph;
		ang[0] = in_item.data.angle_x;
		ang[1] = in_item.data.angle_y;
		ang[2] = in_item.data.angle_z;
		for (int l = 0; l < 3; l++) begin
			ph = {ang[l], 16'h0000} & PHASE_KEEP;
			seed[l].x = CORDIC_GAIN;
			seed[l].y = '0;
			seed[l].z = CW'(ph[29:0]);
			seed[l].quad = ph[31:30];
		end
		side_in.pos_x = in_item.data.pos_x;
		side_in.pos_y = in_item.data.pos_y;
		side_in.pos_z = in_item.data.pos_z;
		side_in.scale_x = in_item.data.scale_x;
		side_in.scale_y = in_item.data.scale_y;
		side_in.scale_z = in_item.data.scale_z;
	end

	assign cd[0] = seed;

	for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_cell
		trs_cordic_cell u_cell (
			.clk(clk),
			.en(adv),
			.step(STEP_W'(k)),
			.d_in(cd[k]),
			.d_out(cd[k+1])
		);
	end

	// Translation and scale travel beside the cells.
	always_ff @(posedge clk) begin
		if (adv) begin
			side_q[1] <= side_in;
			for (int k = 2; k <= CORDIC_STEPS; k++) begin
				side_q[k] <= side_q[k-1];
			end
		end
	end

	trs_mtx_math u_math (
		.clk(clk),
		.en(adv),
		.rot(cd[CORDIC_STEPS]),
		.side(side_q[CORDIC_STEPS]),
		.res(out_item.data)
	);

	// Beat-valid flags follow the data down the pipeline.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 1; k <= CORDIC_STEPS; k++) begin
				v_q[k] <= 1'b0;
			end
			va_q <= 1'b0;
			vb_q <= 1'b0;
			out_v_q <= 1'b0;
		end else if (adv) begin
			v_q[1] <= in_item.valid;
			for (int k = 2; k <= CORDIC_STEPS; k++) begin
				v_q[k] <= v_q[k-1];
			end
			va_q <= v_q[CORDIC_STEPS];
			vb_q <= va_q;
			out_v_q <= vb_q;
		end
	end

	assign out_item.valid = out_v_q;

	`TRS_ASSERT_ALWAYS(a_reset_quiet, !arst_n |-> !out_item.valid, "output valid during reset")
	`TRS_ASSERT(a_ready_rule, in_item.ready == (!out_item.valid || out_item.ready),
		"input ready does not follow the output register")
	`TRS_ASSERT(a_last_stage_lands, vb_q && in_item.ready |=> out_item.valid,
		"beat lost between the sum stage and the output")
endmodule
`default_nettype wire

/* tb/sv/tb_trs_affine_matrix_builder_top.sv */
`default_nettype none
module tb_trs_affine_matrix_builder_top;
	import trs_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	// Cycles without any accepted beat, on either side, before the run is abandoned.
	// The pipeline is 20 deep and the receiver stalls at random at most 86 percent of
	// the time, so this leaves a wide margin.
	localparam int IDLE_LIMIT = 5000;
	// Cycles of the pipeline after the last result, with margin, before the verdict.
	localparam int DRAIN_CYCLES = 40;

	// Holds the matrices still owed by the block and checks each one as it leaves.
	class matrix_scoreboard;
		out_item_t pending[$];
		int errors;

		// CORDIC start vector: 0.6072529 in Q1.30.
		localparam longint CORDIC_START = 652032874;
		static longint atan_turn[17] = '{536870912, 316933406, 167458908, 85004756,
			42667330, 21354465, 10679842, 5340245, 2670163, 1335087, 667544, 333772,
			166886, 83443, 41721, 20861, 10430};

		function new();
			errors = 0;
		endfunction

		// Cosine and sine of a binary angle in Q1.30.
		function void sin_cos(input logic [15:0] ang, output longint c, output longint s);
			logic [31:0] ph;
			longint x, y, z, dx, dy;
			ph = {ang, 16'h0000} & PHASE_KEEP;
			x = CORDIC_START;
			y = 0;
			z = longint'(ph[29:0]);
			for (int i = 0; i < 17; i++) begin
				dx = y >>> i;
				dy = x >>> i;
				if (z >= 0) begin
					x -= dx; y += dy; z -= atan_turn[i];
				end else begin
					x += dx; y -= dy; z += atan_turn[i];
				end
			end
			case (ph[31:30])
				2'd0: begin c = x; s = y; end
				2'd1: begin c = -y; s = x; end
				2'd2: begin c = -x; s = -y; end
				default: begin c = y; s = -x; end
			endcase
		endfunction

		function longint mul_q30(input longint a, input longint b);
			return (a * b + 536870912) >>> 30;
		endfunction

		// Q1.30 entry times Q8.8 scale, rounded to Q16.16 and clamped to 32 bits.
		function logic [31:0] apply_scale(input longint r, input logic signed [15:0] k);
			longint v;
			v = (r * longint'(k) + 2097152) >>> 22;
			if (v > 64'sd2147483647)
				v = 64'sd2147483647;
			if (v < -64'sd2147483648)
				v = -64'sd2147483648;
			return v[31:0];
		endfunction

		function out_item_t build_matrix(input in_item_t it);
			out_item_t m;
			longint cx, sx, cy, sy, cz, sz, sxsy, cxsy;
			sin_cos(it.angle_x, cx, sx);
			sin_cos(it.angle_y, cy, sy);
			sin_cos(it.angle_z, cz, sz);
			sxsy = mul_q30(sx, sy);
			cxsy = mul_q30(cx, sy);
			m.r0c0 = apply_scale(mul_q30(cy, cz), it.scale_x);
			m.r0c1 = apply_scale(-mul_q30(cy, sz), it.scale_y);
			m.r0c2 = apply_scale(sy, it.scale_z);
			m.r0c3 = it.pos_x;
			m.r1c0 = apply_scale(mul_q30(sxsy, cz) + mul_q30(cx, sz), it.scale_x);
			m.r1c1 = apply_scale(-mul_q30(sxsy, sz) + mul_q30(cx, cz), it.scale_y);
			m.r1c2 = apply_scale(-mul_q30(sx, cy), it.scale_z);
			m.r1c3 = it.pos_y;
			m.r2c0 = apply_scale(-mul_q30(cxsy, cz) + mul_q30(sx, sz), it.scale_x);
			m.r2c1 = apply_scale(mul_q30(cxsy, sz) + mul_q30(sx, cz), it.scale_y);
			m.r2c2 = apply_scale(mul_q30(cx, cy), it.scale_z);
			m.r2c3 = it.pos_z;
			return m;
		endfunction

		function void note_entity(input in_item_t it);
			pending.push_back(build_matrix(it));
		endfunction

		task report(input string what);
			$display("[%0t] mismatch: %s", $realtime, what);
			errors++;
		endtask

		task check_matrix(input out_item_t got);
			out_item_t want;
			logic [11:0][31:0] g, w;
			if (pending.size() == 0) begin
				report("matrix beat with none outstanding");
			end else begin
				want = pending.pop_front();
				g = got;
				w = want;
				// Word 11 is r0c0, word 0 is r2c3.
				for (int k = 11; k >= 0; k--) begin
					if (g[k] !== w[k])
						report($sformatf("r%0dc%0d got %08h want %08h",
							(11 - k) / 4, (11 - k) % 4, g[k], w[k]));
				end
			end
		endtask
	endclass

	logic clk;
	logic arst_n;
	trs_in_if in_item();
	trs_out_if out_item();

	trs_affine_matrix_builder_top u_top (
		.clk(clk),
		.arst_n(arst_n),
		.in_item(in_item.sink),
		.out_item(out_item.source)
	);

	matrix_scoreboard board;
	// Percent of cycles in which the sender holds back and the receiver stalls.
	int send_gap_pct;
	int sink_stall_pct;
	int quiet_cycles;

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// The receiver decides its ready at every falling edge from the current stall rate.
	always @(negedge clk) begin
		out_item.ready <= ($urandom_range(99) >= sink_stall_pct);
	end

	// Result side: every accepted beat is checked against the oldest prediction.
	always @(posedge clk) begin
		if (arst_n && out_item.valid && out_item.ready)
			board.check_matrix(out_item.data);
	end

	// Watchdog: a hang on either side shows up as a long run of cycles with no beat.
	always @(posedge clk) begin
		if (!arst_n || (in_item.valid && in_item.ready) ||
				(out_item.valid && out_item.ready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= IDLE_LIMIT) begin
				$display("simulation failed");
				$finish;
			end
		end
	end

	// Presents one entity after a random number of empty cycles and holds it until
	// the block takes it. Valid is left high afterwards, so a following call without
	// a gap keeps the stream back to back; each falling edge sees one assignment.
	task send_entity(input in_item_t it);
		while ($urandom_range(99) < send_gap_pct) begin
			in_item.valid <= 1'b0;
			@(negedge clk);
		end
		in_item.valid <= 1'b1;
		in_item.data <= it;
		do
			@(posedge clk);
		while (!in_item.ready);
		board.note_entity(it);
		@(negedge clk);
	endtask

	// Waits at a falling edge until every outstanding matrix has been checked.
	task wait_drained();
		in_item.valid <= 1'b0;
		@(negedge clk);
		while (board.pending.size() != 0)
			@(negedge clk);
	endtask

	function in_item_t entity(input logic [31:0] px, input logic [31:0] py,
			input logic [31:0] pz, input logic [15:0] ax, input logic [15:0] ay,
			input logic [15:0] az, input logic [15:0] kx, input logic [15:0] ky,
			input logic [15:0] kz);
		in_item_t it;
		it.pos_x = px; it.pos_y = py; it.pos_z = pz;
		it.angle_x = ax; it.angle_y = ay; it.angle_z = az;
		it.scale_x = kx; it.scale_y = ky; it.scale_z = kz;
		return it;
	endfunction

	// Angles drawn mostly at random, sometimes on the quadrant edges where the
	// sine and cosine swap roles.
	function logic [15:0] pick_angle();
		logic [15:0] a;
		case ($urandom_range(7))
			0: a = 16'(($urandom_range(3) << 14));
			1: a = 16'(($urandom_range(3) << 14) + $urandom_range(2)) - 16'd1;
			default: a = 16'($urandom);
		endcase
		return a;
	endfunction

	// Scales are mostly ordinary magnitudes, with the full range mixed in.
	function logic [15:0] pick_scale();
		logic [15:0] k;
		case ($urandom_range(5))
			0: k = 16'($urandom);
			1: k = $urandom_range(1) ? 16'h7FFF : 16'h8000;
			default: k = 16'($signed($urandom_range(2048)) - 1024);
		endcase
		return k;
	endfunction

	function in_item_t random_entity();
		return entity($urandom, $urandom, $urandom, pick_angle(), pick_angle(),
			pick_angle(), pick_scale(), pick_scale(), pick_scale());
	endfunction

	initial begin
		int wait_cycles;
		board = new();
		send_gap_pct = 0;
		sink_stall_pct = 0;
		quiet_cycles = 0;
		// Reset is dropped shortly after time zero so the falling edge is never missed.
		arst_n = 1'b1;
		in_item.valid = 1'b0;
		in_item.data = '0;
		out_item.ready = 1'b0;
		#1;
		arst_n = 1'b0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed entities: identity, extreme translations, every quadrant boundary,
		// the largest angle, and the scale extremes including zero and negative scale.
		send_entity(entity(32'h0, 32'h0, 32'h0, 16'h0, 16'h0, 16'h0,
			16'h0100, 16'h0100, 16'h0100));
		send_entity(entity(32'h7FFFFFFF, 32'h80000000, 32'hFFFFFFFF, 16'h0, 16'h0,
			16'h0, 16'h7FFF, 16'h8000, 16'h0000));
		send_entity(entity(32'h80000000, 32'h7FFFFFFF, 32'h00000001, 16'h4000,
			16'h0, 16'h0, 16'h0100, 16'h0100, 16'h0100));
		send_entity(entity(32'h00010000, 32'h0, 32'h0, 16'h0, 16'h4000, 16'h0,
			16'h0100, 16'h0100, 16'h0100));
		send_entity(entity(32'h0, 32'h00010000, 32'h0, 16'h0, 16'h0, 16'h4000,
			16'h0100, 16'h0100, 16'h0100));
		send_entity(entity(32'h0, 32'h0, 32'h00010000, 16'h8000, 16'h8000, 16'h8000,
			16'hFF00, 16'hFF00, 16'hFF00));
		send_entity(entity(32'h12345678, 32'h9ABCDEF0, 32'h0F0F0F0F, 16'hC000,
			16'hC000, 16'hC000, 16'h7FFF, 16'h7FFF, 16'h7FFF));
		send_entity(entity(32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 16'hFFFF,
			16'hFFFF, 16'hFFFF, 16'h8000, 16'h8000, 16'h8000));
		send_entity(entity(32'h0, 32'h0, 32'h0, 16'h0001, 16'h0001, 16'h0001,
			16'h8000, 16'h7FFF, 16'h0001));
		send_entity(entity(32'h0, 32'h0, 32'h0, 16'h3FFF, 16'h7FFF, 16'hBFFF,
			16'h0000, 16'h0000, 16'h0000));
		send_entity(entity(32'h55555555, 32'hAAAAAAAA, 32'h33333333, 16'h2000,
			16'h6000, 16'hE000, 16'h7FFF, 16'h8000, 16'h7FFF));
		send_entity(entity(32'hAAAAAAAA, 32'h55555555, 32'hCCCCCCCC, 16'h00FF,
			16'hFF00, 16'h5555, 16'hFFFF, 16'h0001, 16'h8001));
		// Hold the sender until the pipeline is empty before the random phases.
		wait_drained();

		// Random phases: back to back, idle sender, stalling receiver, then both.
		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin send_gap_pct = 0; sink_stall_pct = 0; end
				1: begin send_gap_pct = 86; sink_stall_pct = 0; end
				2: begin send_gap_pct = 0; sink_stall_pct = 86; end
				default: begin send_gap_pct = 25; sink_stall_pct = 25; end
			endcase
			for (int n = 0; n < 225; n++)
				send_entity(random_entity());
			in_item.valid <= 1'b0;
			@(negedge clk);
		end
		sink_stall_pct = 0;

		in_item.valid <= 1'b0;
		wait_cycles = 0;
		while (board.pending.size() != 0 && wait_cycles < 100000) begin
			@(negedge clk);
			wait_cycles++;
		end
		if (board.pending.size() != 0) begin
			$display("simulation failed");
		end else begin
			repeat (DRAIN_CYCLES) @(negedge clk);
			if (board.errors == 0 && board.pending.size() == 0) begin
				$display("simulation ok");
			end else begin
				$display("simulation failed");
			end
		end
		$finish;
	end
endmodule
`default_nettype wire

/* filelist.f */
+incdir+rtl
rtl/trs_pkg.sv
rtl/trs_in_if.sv
rtl/trs_out_if.sv
rtl/trs_cordic_cell.sv
rtl/trs_mtx_math.sv
rtl/trs_affine_matrix_builder_top.sv
tb/sv/tb_trs_affine_matrix_builder_top.sv
